@@ rtl/core/ffsc_pkg.sv @@
// Shared types and constants of the flat shading and culling block.
package ffsc_pkg;

  localparam int unsigned NumCfgRegs = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CoordFracBits = 15;
  localparam int unsigned ScreenBits = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_LIGHT_X = 3'd2,
    CFG_LIGHT_Y = 3'd3,
    CFG_LIGHT_Z = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } vtx_t;

  typedef struct packed {
    vtx_t v0;
    vtx_t v1;
    vtx_t v2;
  } face_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_CROSS,
    BK_NORM,
    BK_DOT,
    BK_SQRT,
    BK_DIV,
    BK_EMIT
  } bk_state_e;

endpackage

@@ rtl/core/ffsc_front.sv @@
// Front part: collects three vertices into a face and queues it.
module ffsc_front
  import ffsc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  vtx_t  in_vtx_i,
  output logic  face_valid_o,
  input  logic  face_ready_i,
  output face_t face_o
);

  logic [1:0] phase_q, phase_d;
  vtx_t       v0_q, v1_q;
  face_t      fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop, acc;

  assign in_ready_o   = (phase_q != 2'd2) || (cnt_q != 2'd2);
  assign acc          = in_valid_i && in_ready_o;
  assign push         = acc && (phase_q == 2'd2);
  assign pop          = face_valid_o && face_ready_i;
  assign face_valid_o = cnt_q != 2'd0;
  assign face_o       = fifo_q[rd_q];

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && phase_q == 2'd0) v0_q <= in_vtx_i;
    if (acc && phase_q == 2'd1) v1_q <= in_vtx_i;
    if (push) fifo_q[wr_q] <= '{v0: v0_q, v1: v1_q, v2: in_vtx_i};
  end

endmodule

@@ rtl/core/ffsc_back.sv @@
// Back part: normal, culling, intensity and per-vertex output words.
module ffsc_back
  import ffsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               face_valid_i,
  output logic               face_ready_o,
  input  face_t              face_i,
  input  logic [12:0]        width_i,
  input  logic [12:0]        height_i,
  input  logic signed [15:0] light_x_i,
  input  logic signed [15:0] light_y_i,
  input  logic signed [15:0] light_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [71:0]        out_data_o,
  output logic               out_last_o
);

  localparam int unsigned ScrShift = CoordFracBits + 1;
  localparam logic [12:0] ScrMax = 13'(1 << ScreenBits);

  bk_state_e state_q, state_d;
  face_t     f_q;
  logic signed [16:0] e1_q [3], e2_q [3];
  logic signed [33:0] pa_q [3], pb_q [3];
  logic signed [34:0] n_q [3];
  logic [34:0] mag_q [3];
  logic [5:0]  cnt_q;
  logic [63:0] sum_q, rem_q, root_q, bit_q;
  logic signed [49:0] dot_q;
  logic [50:0] num_q, quo_q;
  logic [1:0]  vi_q;
  logic [16:0] inten_q;

  logic [34:0] mx;
  logic [34:0] nabs [3];
  logic [65:0] dpart;
  logic signed [49:0] dterm;
  logic [29:0] msel;
  logic        nneg;
  logic signed [15:0] lsel;
  logic signed [30:0] nsel;
  logic [51:0] trial;
  vtx_t cur;
  logic signed [17:0] px, py;
  logic signed [31:0] prodx, prody;
  logic [12:0] sx, sy;
  logic [15:0] cr, cg, cb;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nabs[k] = n_q[k][34] ? 35'(-n_q[k]) : 35'(n_q[k]);
    end
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
  end

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin
        msel = mag_q[0][29:0];
        nneg = n_q[0][34];
        lsel = light_x_i;
      end
      2'd1: begin
        msel = mag_q[1][29:0];
        nneg = n_q[1][34];
        lsel = light_y_i;
      end
      default: begin
        msel = mag_q[2][29:0];
        nneg = n_q[2][34];
        lsel = light_z_i;
      end
    endcase
    nsel  = nneg ? -$signed({1'b0, msel}) : $signed({1'b0, msel});
    dterm = 50'(nsel) * 50'(lsel);
    dpart = 66'(msel) * 66'(msel);
    trial = {rem_q[50:0], num_q[50]} - {1'b0, root_q[50:0]};
  end

  always_comb begin
    unique case (vi_q)
      2'd0:    cur = f_q.v0;
      2'd1:    cur = f_q.v1;
      default: cur = f_q.v2;
    endcase
    px = 18'(cur.x) + 18'(1 << CoordFracBits);
    py = 18'(cur.y) + 18'(1 << CoordFracBits);
    prodx = 32'(px) * $signed({19'd0, width_i});
    prody = 32'(py) * $signed({19'd0, height_i});
    if (prodx <= 0) sx = '0;
    else if ((32'(prodx) >> ScrShift) > 32'(ScrMax)) sx = ScrMax;
    else sx = 13'(32'(prodx) >> ScrShift);
    if (prody <= 0) sy = '0;
    else if ((32'(prody) >> ScrShift) > 32'(ScrMax)) sy = ScrMax;
    else sy = 13'(32'(prody) >> ScrShift);
    cr = 16'((25'(cur.r) * 25'(inten_q)) >> 16);
    cg = 16'((25'(cur.g) * 25'(inten_q)) >> 16);
    cb = 16'((25'(cur.b) * 25'(inten_q)) >> 16);
  end

  assign face_ready_o = state_q == BK_IDLE;
  assign out_valid_o  = state_q == BK_EMIT;
  assign out_last_o   = vi_q == 2'd2;
  assign out_data_o   = {6'd0, cb[7:0], cg[7:0], cr[7:0], cur.z, sy, sx};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (face_valid_i) state_d = BK_MUL;
      BK_MUL:   state_d = BK_CROSS;
      BK_CROSS: state_d = BK_NORM;
      BK_NORM: begin
        if (mx == '0) state_d = BK_IDLE;
        else if (cnt_q != 6'd0 && mx[34:29] == 6'd1) state_d = BK_DOT;
      end
      BK_DOT: begin
        if (cnt_q == 6'd3) state_d = (dot_q > 0) ? BK_SQRT : BK_IDLE;
      end
      BK_SQRT:  if (bit_q == '0) state_d = BK_DIV;
      BK_DIV:   if (cnt_q == 6'd52) state_d = BK_EMIT;
      BK_EMIT:  if (out_ready_i && vi_q == 2'd2) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        f_q <= face_i;
        e1_q[0] <= 17'(face_i.v1.x) - 17'(face_i.v0.x);
        e1_q[1] <= 17'(face_i.v1.y) - 17'(face_i.v0.y);
        e1_q[2] <= 17'(face_i.v1.z) - 17'(face_i.v0.z);
        e2_q[0] <= 17'(face_i.v2.x) - 17'(face_i.v0.x);
        e2_q[1] <= 17'(face_i.v2.y) - 17'(face_i.v0.y);
        e2_q[2] <= 17'(face_i.v2.z) - 17'(face_i.v0.z);
        vi_q <= 2'd0;
      end
      BK_MUL: begin
        pa_q[0] <= e2_q[1] * e1_q[2];
        pb_q[0] <= e2_q[2] * e1_q[1];
        pa_q[1] <= e2_q[2] * e1_q[0];
        pb_q[1] <= e2_q[0] * e1_q[2];
        pa_q[2] <= e2_q[0] * e1_q[1];
        pb_q[2] <= e2_q[1] * e1_q[0];
      end
      BK_CROSS: begin
        for (int k = 0; k < 3; k++) begin
          n_q[k] <= 35'(pa_q[k]) - 35'(pb_q[k]);
          mag_q[k] <= 35'(pa_q[k]) - 35'(pb_q[k]) >= 0 ?
                      35'(pa_q[k]) - 35'(pb_q[k]) : 35'(pb_q[k]) - 35'(pa_q[k]);
        end
        cnt_q <= '0;
        dot_q <= '0;
        sum_q <= '0;
      end
      BK_NORM: begin
        if (mx == '0) begin
        end else if (cnt_q == 6'd0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= nabs[k];
          cnt_q <= 6'd1;
        end else if (mx[34:30] != '0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
        end else if (mx[29] == 1'b0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
        end else begin
          cnt_q <= '0;
        end
      end
      BK_DOT: begin
        if (cnt_q != 6'd3) begin
          dot_q <= dot_q + dterm;
          sum_q <= sum_q + dpart[63:0];
        end
        cnt_q  <= cnt_q + 6'd1;
        rem_q  <= sum_q;
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      BK_SQRT: begin
        if (bit_q != '0) begin
          if (bit_q > rem_q && root_q == '0) begin
            bit_q <= bit_q >> 2;
          end else if (rem_q >= root_q + bit_q) begin
            rem_q  <= rem_q - (root_q + bit_q);
            root_q <= (root_q >> 1) + bit_q;
            bit_q  <= bit_q >> 2;
          end else begin
            root_q <= root_q >> 1;
            bit_q  <= bit_q >> 2;
          end
        end
        num_q <= {dot_q[49:0], 1'b0};
        cnt_q <= '0;
      end
      BK_DIV: begin
        if (cnt_q == 6'd0) begin
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= 6'd1;
        end else if (cnt_q != 6'd52) begin
          if (!trial[51]) begin
            rem_q <= 64'(trial[50:0]);
            quo_q <= {quo_q[49:0], 1'b1};
          end else begin
            rem_q <= {rem_q[62:0], num_q[50]};
            quo_q <= {quo_q[49:0], 1'b0};
          end
          num_q <= num_q << 1;
          if (cnt_q == 6'd51) cnt_q <= 6'd52;
          else cnt_q <= cnt_q + 6'd1;
        end
        inten_q <= (quo_q > 51'd65536) ? 17'd65536 : 17'(quo_q);
      end
      BK_EMIT: begin
        if (out_ready_i) vi_q <= vi_q + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/face_flat_shade_and_cull.sv @@
// Top level of the flat shading and back-face culling block.
// Vertices enter on the s_axis channel, one word each; every third word
// closes a face. The front part buffers up to two complete faces, so input
// keeps flowing while the back part works. The back part forms the face
// normal, normalizes it, takes the dot product with the light and then an
// integer square root and a 51-step bit-serial divide for the intensity.
// In the back part, the time a visible face takes from its acceptance to
// the last word varies with the normal's shift count, while the square
// root and the divider take the bulk of it. A culled face (zero area, or
// facing away) gives no words; a visible one gives three m_axis words,
// the third with tlast set. Configuration is written on cfg_we_i with an
// index and data; the user writes it only while idle, which the block does
// not enforce. Reset clears the vertex count, the face queue and the
// back-part state and loads width 700, height 700 and light (0, 0, -1).
// When the receiver holds m_axis_tready low the current word stays; the
// queue still takes up to two faces before s_axis_tready falls.
module face_flat_shade_and_cull
  import ffsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, pos_z, texel_red, texel_green, texel_blue
  input  logic [71:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // screen_x, screen_y, depth, shaded_red, shaded_green, shaded_blue
  output logic [71:0]         m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [12:0] width_q, height_q;
  logic signed [15:0] lx_q, ly_q, lz_q;
  vtx_t  vin;
  face_t face;
  logic  face_valid, face_ready;

  assign vin = '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16], z: s_axis_tdata[47:32],
                 r: s_axis_tdata[55:48], g: s_axis_tdata[63:56], b: s_axis_tdata[71:64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd700;
      height_q <= 13'd700;
      lx_q     <= '0;
      ly_q     <= '0;
      lz_q     <= 16'sh8000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:   width_q  <= cfg_data_i[12:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[12:0];
        CFG_LIGHT_X: lx_q     <= cfg_data_i;
        CFG_LIGHT_Y: ly_q     <= cfg_data_i;
        CFG_LIGHT_Z: lz_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ffsc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_vtx_i     (vin),
    .face_valid_o (face_valid),
    .face_ready_i (face_ready),
    .face_o       (face)
  );

  ffsc_back u_back (
    .clk_i, .rst_ni,
    .face_valid_i (face_valid),
    .face_ready_o (face_ready),
    .face_i       (face),
    .width_i      (width_q),
    .height_i     (height_q),
    .light_x_i    (lx_q),
    .light_y_i    (ly_q),
    .light_z_i    (lz_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_last_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("word after last of face");
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    face_ready |-> !m_axis_tvalid)
    else $error("output while back part idle");

endmodule
